### rtl/single_wire_humidity_sensor_reader_defines.svh
// Assertion macros shared by the single-wire humidity sensor reader RTL.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_DEFINES_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_DEFINES_SVH

// Clocked check, masked while reset is high.
`define SWHSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SWHSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/swhsr_pkg.sv
// Shared types and constants for the single-wire humidity sensor reader.
`timescale 1ns / 1ps
package swhsr_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_START_LOW     = 3'd0;
  localparam logic [2:0] REG_START_HIGH    = 3'd1;
  localparam logic [2:0] REG_RESP_TIMEOUT  = 3'd2;
  localparam logic [2:0] REG_BIT_LOW_TMO   = 3'd3;
  localparam logic [2:0] REG_BIT_HIGH_TMO  = 3'd4;
  localparam logic [2:0] REG_ONE_THRESHOLD = 3'd5;

  // Register reset values
  localparam logic [15:0] START_LOW_RST     = 16'd25000;
  localparam logic [7:0]  START_HIGH_RST    = 8'd25;
  localparam logic [7:0]  RESP_TIMEOUT_RST  = 8'd85;
  localparam logic [7:0]  BIT_LOW_TMO_RST   = 8'd56;
  localparam logic [7:0]  BIT_HIGH_TMO_RST  = 8'd75;
  localparam logic [7:0]  ONE_THRESHOLD_RST = 8'd40;

  localparam logic [5:0] FRAME_BITS = 6'd40;

  // Item kinds
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Completion status
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
  localparam logic [1:0] STATUS_CSUM_ERR = 2'd2;

  typedef struct packed {
    logic [15:0] start_low_time;
    logic [7:0]  start_high_time;
    logic [7:0]  response_timeout;
    logic [7:0]  bit_low_timeout;
    logic [7:0]  bit_high_timeout;
    logic [7:0]  one_threshold;
  } cfg_t;

  typedef struct packed {
    logic [7:0] temperature;
    logic [7:0] humidity;
    logic [1:0] status;
    logic       done_res;
    logic       busy_res;
    logic       drive_level;
    logic       drive_enable;
  } result_t;

endpackage

### rtl/swhsr_core.sv
// Protocol sequencer: start pulse, response timing, bit decode and checksum.
`timescale 1ns / 1ps
module swhsr_core
  import swhsr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  logic    op,
  input  logic    pin_level,
  output result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_START_LOW, PH_START_HIGH, PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_next, tick_inc;
  logic [5:0]  bit_count, bit_next, bit_inc;
  logic [39:0] frame_shift, frame_next, frame_new;
  logic [7:0]  humidity_reg, humidity_next;
  logic [7:0]  temperature_reg, temperature_next;
  logic [7:0]  limit, csum;
  logic        wait_level, new_bit, done;
  logic [1:0]  status;

  // Level the current sensor phase waits on, and its tick limit
  always_comb begin
    wait_level = 1'b0;
    limit      = cfg.response_timeout;
    case (phase)
      PH_RESP_LOW:  begin wait_level = 1'b0; limit = cfg.response_timeout; end
      PH_RESP_HIGH: begin wait_level = 1'b1; limit = cfg.response_timeout; end
      PH_BIT_LOW:   begin wait_level = 1'b0; limit = cfg.bit_low_timeout;  end
      PH_BIT_HIGH:  begin wait_level = 1'b1; limit = cfg.bit_high_timeout; end
      default: ;
    endcase
  end

  assign tick_inc  = tick_count + 16'd1;
  assign bit_inc   = bit_count + 6'd1;
  assign new_bit   = (tick_count > {8'd0, cfg.one_threshold});
  assign frame_new = {frame_shift[38:0], new_bit};
  assign csum      = frame_new[39:32] + frame_new[31:24] + frame_new[23:16] + frame_new[15:8];

  always_comb begin
    phase_next       = phase;
    tick_next        = tick_count;
    bit_next         = bit_count;
    frame_next       = frame_shift;
    humidity_next    = humidity_reg;
    temperature_next = temperature_reg;
    done             = 1'b0;
    status           = STATUS_OK;
    if (op == OP_START) begin
      // start while busy is dropped, and does not count as a tick
      if (phase == PH_IDLE) begin
        phase_next = PH_START_LOW;
        tick_next  = 16'd0;
        bit_next   = 6'd0;
        frame_next = 40'd0;
      end
    end else begin
      case (phase)
        PH_IDLE: ;
        PH_START_LOW: begin
          tick_next = tick_inc;
          if (tick_inc >= cfg.start_low_time || tick_inc == 16'd0) begin
            phase_next = PH_START_HIGH;
            tick_next  = 16'd0;
          end
        end
        PH_START_HIGH: begin
          tick_next = tick_inc;
          // release tick: the line is not sampled here
          if (tick_inc >= {8'd0, cfg.start_high_time} || tick_inc == 16'd0) begin
            phase_next = PH_RESP_LOW;
            tick_next  = 16'd0;
          end
        end
        default: begin
          if (pin_level == wait_level) begin
            if (tick_count > {8'd0, limit}) begin
              phase_next = PH_IDLE;
              tick_next  = 16'd0;
              done       = 1'b1;
              status     = STATUS_TIMEOUT;
            end else begin
              tick_next = tick_inc;
            end
          end else if (phase == PH_BIT_HIGH) begin
            frame_next = frame_new;
            bit_next   = bit_inc;
            if (bit_inc >= FRAME_BITS) begin
              phase_next = PH_IDLE;
              tick_next  = 16'd0;
              done       = 1'b1;
              if (csum == frame_new[7:0]) begin
                humidity_next    = frame_new[39:32];
                temperature_next = frame_new[23:16];
                status           = STATUS_OK;
              end else begin
                status = STATUS_CSUM_ERR;
              end
            end else begin
              phase_next = PH_BIT_LOW;
              tick_next  = 16'd1;
            end
          end else begin
            // edge seen: this sample is the first tick of the next phase
            phase_next = (phase == PH_BIT_LOW) ? PH_BIT_HIGH : phase_t'(phase + 3'd1);
            tick_next  = 16'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_count      <= 16'd0;
      bit_count       <= 6'd0;
      frame_shift     <= 40'd0;
      humidity_reg    <= 8'd0;
      temperature_reg <= 8'd0;
    end else if (fire) begin
      phase           <= phase_next;
      tick_count      <= tick_next;
      bit_count       <= bit_next;
      frame_shift     <= frame_next;
      humidity_reg    <= humidity_next;
      temperature_reg <= temperature_next;
    end
  end

  // Result reflects the state after this beat
  always_comb begin
    res.drive_enable = (phase_next == PH_START_LOW) || (phase_next == PH_START_HIGH);
    res.drive_level  = (phase_next == PH_START_HIGH);
    res.busy_res     = (phase_next != PH_IDLE);
    res.done_res     = done;
    res.status       = status;
    res.humidity     = humidity_next;
    res.temperature  = temperature_next;
  end

endmodule

### rtl/single_wire_humidity_sensor_reader.sv
// Top level of the single-wire humidity sensor reader: config, sequencer and output queue.
`timescale 1ns / 1ps
// Latency: a result beat appears on the master side the cycle after its input beat unless older ones wait.
// Throughput: one input beat per cycle; a two-entry output queue keeps the slave side
//   open while a result waits, so tready drops only when two results are pending.
// Reset (rst, synchronous): sequencer to idle, counters, frame and latched readings to
//   zero, registers to their default timings, output queue emptied.
`include "single_wire_humidity_sensor_reader_defines.svh"
module single_wire_humidity_sensor_reader
  import swhsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
  input  logic        s_axis_tuser,   // [0] op (0 tick, 1 start)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] drive_enable, [1] drive_level, [2] busy_res, [3] done_res, [5:4] status,
  // [13:6] humidity, [21:14] temperature, [23:22] zero
  output logic [23:0] m_axis_tdata
);

  cfg_t       cfg;
  result_t    res;
  result_t    q0, q1;   // q0 is the head
  logic [1:0] out_count;
  logic       push, pop;

  // Configuration registers; the host must write them only while no beat is in flight; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_time   <= START_LOW_RST;
      cfg.start_high_time  <= START_HIGH_RST;
      cfg.response_timeout <= RESP_TIMEOUT_RST;
      cfg.bit_low_timeout  <= BIT_LOW_TMO_RST;
      cfg.bit_high_timeout <= BIT_HIGH_TMO_RST;
      cfg.one_threshold    <= ONE_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_LOW:     cfg.start_low_time   <= cfg_data;
        REG_START_HIGH:    cfg.start_high_time  <= cfg_data[7:0];
        REG_RESP_TIMEOUT:  cfg.response_timeout <= cfg_data[7:0];
        REG_BIT_LOW_TMO:   cfg.bit_low_timeout  <= cfg_data[7:0];
        REG_BIT_HIGH_TMO:  cfg.bit_high_timeout <= cfg_data[7:0];
        REG_ONE_THRESHOLD: cfg.one_threshold    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (out_count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (out_count != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;

  swhsr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fire      (push),
    .op        (s_axis_tuser),
    .pin_level (s_axis_tdata[0]),
    .res       (res)
  );

  // Two-entry result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (out_count == 2'd0) q0 <= res;
          else q1 <= res;
          out_count <= out_count + 2'd1;
        end
        2'b01: begin
          q0        <= q1;
          out_count <= out_count - 2'd1;
        end
        2'b11: begin
          if (out_count == 2'd1) begin
            q0 <= res;
          end else begin
            q0 <= q1;
            q1 <= res;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {2'b00, q0};

  `SWHSR_ASSERT(a_pop_drains, (pop && !push) |=> (out_count == $past(out_count) - 2'd1), "queue count did not drop on a lone pop")
  `SWHSR_ASSERT(a_done_not_busy, (push && res.done_res) |-> !res.busy_res, "reading finished but still busy")
  `SWHSR_ASSERT(a_status_with_done, (push && !res.done_res) |-> (res.status == STATUS_OK), "nonzero status without done")
  `SWHSR_ASSERT(a_level_needs_drive, (push && res.drive_level) |-> res.drive_enable, "drive level high while line released")
  `SWHSR_ASSERT(a_count_range, out_count != 2'd3, "output queue count out of range")
  `SWHSR_ASSERT_ALWAYS(a_reset_empties, rst |=> (out_count == 2'd0), "output queue not empty after reset")

endmodule

### verif/tb_top.sv
// Self-checking testbench for the single-wire humidity sensor reader.
`timescale 1ns / 1ps
module tb_top;
  import swhsr_pkg::*;

  // Cycles with no beat on either side, and no register write, before the run is
  // declared hung. Longest legit quiet stretch is an idle gap or a readout stall.
  localparam int unsigned STALL_LIMIT = 5000;
  // Mismatch lines printed before going silent (all are still counted).
  localparam int unsigned MAX_PRINTED = 30;
  // Sensor frame: 40 data bits, plus the two response runs.
  localparam int LINE_RUNS = 2 + 2 * int'(FRAME_BITS);

  // Sequencer phases as the predictor tracks them.
  typedef enum logic [2:0] {
    LINE_IDLE,
    LINE_START_LOW,
    LINE_START_HIGH,
    SENSOR_RESP_LOW,
    SENSOR_RESP_HIGH,
    SENSOR_BIT_LOW,
    SENSOR_BIT_HIGH
  } line_phase_t;

  // Predicts one readout per accepted input beat and checks readouts in order.
  class reading_scoreboard;
    cfg_t        cfg;
    line_phase_t phase;
    logic [15:0] ticks;
    int unsigned bits_in;
    logic [39:0] frame;
    logic [7:0]  humidity_q;
    logic [7:0]  temperature_q;
    result_t     expected_readouts[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned good_frames;
    int unsigned timeouts;
    int unsigned bad_sums;

    function new();
      cfg = '{START_LOW_RST, START_HIGH_RST, RESP_TIMEOUT_RST, BIT_LOW_TMO_RST,
              BIT_HIGH_TMO_RST, ONE_THRESHOLD_RST};
      phase = LINE_IDLE;
      ticks = '0;
      bits_in = 0;
      frame = '0;
      humidity_q = '0;
      temperature_q = '0;
    endfunction

    function int unsigned pending();
      return expected_readouts.size();
    endfunction

    function void accept_sample(logic op, logic pin);
      result_t    r;
      logic       wait_level;
      logic [7:0] lim;
      logic [7:0] sum;
      logic       done;
      logic [1:0] st;
      done = 1'b0;
      st = STATUS_OK;
      if (op == OP_START) begin
        // a start while a reading runs is dropped and is not a tick either
        if (phase == LINE_IDLE) begin
          phase = LINE_START_LOW;
          ticks = '0;
          bits_in = 0;
          frame = '0;
        end
      end else begin
        case (phase)
          LINE_START_LOW: begin
            ticks = ticks + 16'd1;
            if (ticks >= cfg.start_low_time || ticks == 16'd0) begin
              phase = LINE_START_HIGH;
              ticks = '0;
            end
          end
          LINE_START_HIGH: begin
            // the tick ending this phase is the release tick, pin not sampled
            ticks = ticks + 16'd1;
            if (ticks >= {8'd0, cfg.start_high_time} || ticks == 16'd0) begin
              phase = SENSOR_RESP_LOW;
              ticks = '0;
            end
          end
          SENSOR_RESP_LOW, SENSOR_RESP_HIGH, SENSOR_BIT_LOW, SENSOR_BIT_HIGH: begin
            wait_level = (phase == SENSOR_RESP_HIGH || phase == SENSOR_BIT_HIGH);
            if (phase == SENSOR_RESP_LOW || phase == SENSOR_RESP_HIGH) lim = cfg.response_timeout;
            else if (phase == SENSOR_BIT_LOW) lim = cfg.bit_low_timeout;
            else lim = cfg.bit_high_timeout;
            if (pin == wait_level) begin
              if (ticks > {8'd0, lim}) begin
                phase = LINE_IDLE;
                ticks = '0;
                done = 1'b1;
                st = STATUS_TIMEOUT;
              end else begin
                ticks = ticks + 16'd1;
              end
            end else if (phase == SENSOR_BIT_HIGH) begin
              // falling edge closes the bit cell; length decides the bit
              frame = {frame[38:0], ticks > {8'd0, cfg.one_threshold}};
              bits_in++;
              if (bits_in >= int'(FRAME_BITS)) begin
                sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
                phase = LINE_IDLE;
                ticks = '0;
                done = 1'b1;
                if (sum == frame[7:0]) begin
                  humidity_q = frame[39:32];
                  temperature_q = frame[23:16];
                end else begin
                  st = STATUS_CSUM_ERR;
                end
              end else begin
                phase = SENSOR_BIT_LOW;
                ticks = 16'd1;
              end
            end else begin
              // edge sample opens the next phase as its first tick
              phase = (phase == SENSOR_BIT_LOW) ? SENSOR_BIT_HIGH : line_phase_t'(phase + 3'd1);
              ticks = 16'd1;
            end
          end
          default: ;
        endcase
      end
      if (done) begin
        if (st == STATUS_OK) good_frames++;
        else if (st == STATUS_TIMEOUT) timeouts++;
        else bad_sums++;
      end
      r.drive_enable = (phase == LINE_START_LOW || phase == LINE_START_HIGH);
      r.drive_level = (phase == LINE_START_HIGH);
      r.busy_res = (phase != LINE_IDLE);
      r.done_res = done;
      r.status = st;
      r.humidity = humidity_q;
      r.temperature = temperature_q;
      expected_readouts.push_back(r);
    endfunction

    task report(string what, longint unsigned exp_v, longint unsigned got_v);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
    endtask

    task check_readout(logic [23:0] beat);
      result_t got;
      result_t exp;
      got = beat[21:0];
      if (expected_readouts.size() == 0) begin
        report("readout with no input pending", 0, beat);
        return;
      end
      exp = expected_readouts.pop_front();
      checked++;
      if (got.drive_enable !== exp.drive_enable)
        report("drive_enable", exp.drive_enable, got.drive_enable);
      if (got.drive_level !== exp.drive_level)
        report("drive_level", exp.drive_level, got.drive_level);
      if (got.busy_res !== exp.busy_res) report("busy", exp.busy_res, got.busy_res);
      if (got.done_res !== exp.done_res) report("done", exp.done_res, got.done_res);
      if (got.status !== exp.status) report("status", exp.status, got.status);
      if (got.humidity !== exp.humidity) report("humidity", exp.humidity, got.humidity);
      if (got.temperature !== exp.temperature)
        report("temperature", exp.temperature, got.temperature);
      if (beat[23:22] !== 2'b00) report("tdata pad bits", 0, beat[23:22]);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] pin_level, [7:1] zero
  logic        s_axis_tuser = 1'b0; // [0] op (0 tick, 1 start)
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] drive_enable, [1] drive_level, [2] busy, [3] done, [5:4] status,
  // [13:6] humidity, [21:14] temperature, [23:22] zero
  logic [23:0] m_axis_tdata;

  reading_scoreboard sb;
  bit                smooth = 1'b0;  // when set, neither side idles
  int unsigned       busy_beats = 0; // beats that start or advance a reading
  int unsigned       timing_sets = 0;

  single_wire_humidity_sensor_reader DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (smooth) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Readout side: ready in runs, with random stalls in between.
  initial begin : readout_sink
    int unsigned stall;
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      stall = idle_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Readout monitor: every accepted beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_readout(m_axis_tdata);
  end

  // Hang detector.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("single_wire_humidity_sensor_reader verification failed");
    $finish;
  end

  // One input beat. tvalid stays high on return so a following beat can go
  // back-to-back; wait_quiet drops it.
  task automatic send_beat(logic op, logic pin);
    int unsigned gap;
    gap = idle_gap();
    if (op == OP_START || sb.phase != LINE_IDLE) busy_beats++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, pin};
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.accept_sample(op, pin);
  endtask

  // Sender holds off until every predicted readout has come back.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes all six timing registers while the block is idle.
  task automatic program_timing(cfg_t c);
    logic [2:0]  idx;
    logic [15:0] value;
    wait_quiet();
    for (int i = 0; i <= int'(REG_ONE_THRESHOLD); i++) begin
      idx = 3'(i);
      // 8-bit registers get junk in the upper byte; it must be ignored
      case (idx)
        REG_START_LOW:     value = c.start_low_time;
        REG_START_HIGH:    value = {8'($urandom), c.start_high_time};
        REG_RESP_TIMEOUT:  value = {8'($urandom), c.response_timeout};
        REG_BIT_LOW_TMO:   value = {8'($urandom), c.bit_low_timeout};
        REG_BIT_HIGH_TMO:  value = {8'($urandom), c.bit_high_timeout};
        REG_ONE_THRESHOLD: value = {8'($urandom), c.one_threshold};
        default:           value = '0;
      endcase
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= value;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sb.cfg = c;
    timing_sets++;
  endtask

  // A run of samples at one line level, with the odd start request mixed in
  // (busy, so dropped).
  task automatic line_run(logic level, int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) send_beat(OP_START, 1'($urandom_range(0, 1)));
      send_beat(OP_TICK, level);
    end
  endtask

  // One sensor transaction: start request, host drive, then the sensor's response
  // and 40 bit cells encoding a frame. cut_run picks a run that is held past its
  // limit to force a timeout (-1: none).
  task automatic read_sensor(bit corrupt_sum, int cut_run);
    logic [39:0] word;
    logic [7:0]  sum;
    logic        level;
    int          lim;
    int          thr;
    int          len;
    word[39:8] = $urandom;
    sum = word[39:32] + word[31:24] + word[23:16] + word[15:8];
    word[7:0] = corrupt_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    thr = int'(sb.cfg.one_threshold);
    send_beat(OP_START, 1'($urandom_range(0, 1)));
    // host drive phases; pin is don't-care, including the release tick
    while (sb.phase == LINE_START_LOW || sb.phase == LINE_START_HIGH) begin
      if ($urandom_range(0, 29) == 0) send_beat(OP_START, 1'($urandom_range(0, 1)));
      send_beat(OP_TICK, 1'($urandom_range(0, 1)));
    end
    // runs: 0 response low, 1 response high, then low/high per data bit
    for (int run_no = 0; run_no < LINE_RUNS; run_no++) begin
      level = run_no[0];
      if (run_no < 2) lim = int'(sb.cfg.response_timeout);
      else if (level) lim = int'(sb.cfg.bit_high_timeout);
      else lim = int'(sb.cfg.bit_low_timeout);
      if (run_no == cut_run) begin
        len = lim + 2;
      end else if (run_no >= 3 && level) begin
        if (word[39 - (run_no - 3) / 2]) len = thr + 1 + $urandom_range(0, 3);
        else len = (thr == 0) ? 1 : $urandom_range(1, (thr < 4) ? thr : 4);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, lim + 1) : $urandom_range(1, 4);
      end
      if (len > lim + 1 && run_no != cut_run) len = lim + 1;
      line_run(level, len);
      if (sb.phase == LINE_IDLE) return;
    end
    send_beat(OP_TICK, 1'b0);  // last falling edge clocks in bit 39
  endtask

  // Line held low until whatever reading is open finishes (drive or timeout).
  task automatic to_idle();
    while (sb.phase != LINE_IDLE) send_beat(OP_TICK, 1'b0);
  endtask

  initial begin : stimulus
    cfg_t        c;
    int unsigned sel;
    int unsigned readings;
    int unsigned base;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // ticks while idle do nothing
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    // zero drive times and zero limits: each phase lasts one tick
    program_timing('0);
    // response low held too long; second start is dropped while busy
    send_beat(OP_START, 1'b1);
    send_beat(OP_START, 1'b0);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);  // release tick, pin ignored
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b0);
    // response high held too long
    send_beat(OP_START, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b1);
    // bit low held too long
    send_beat(OP_START, 1'b1);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b0);
    // bit high held too long
    send_beat(OP_START, 1'b0);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b1);
    to_idle();
    // zero threshold: every bit reads 1, so the checksum fails
    read_sensor(1'b0, -1);
    to_idle();

    // --- random: short timings, mostly well-formed frames ---
    readings = 0;
    base = busy_beats;
    while (busy_beats - base < 420 || readings < 6) begin
      if (readings % 3 == 0) begin
        c.start_low_time = $urandom_range(0, 6);
        c.start_high_time = $urandom_range(0, 4);
        c.response_timeout = $urandom_range(0, 8);
        c.bit_low_timeout = $urandom_range(0, 5);
        c.bit_high_timeout = $urandom_range(1, 10);
        c.one_threshold = $urandom_range(0, 6);
        program_timing(c);
      end
      smooth = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        read_sensor(1'b0, -1);
      end else if (sel == 6) begin
        read_sensor(1'b1, -1);
      end else if (sel == 7) begin
        read_sensor(1'b0, $urandom_range(0, LINE_RUNS - 1));
      end else begin
        // garbage on the line, starts mixed in
        send_beat(OP_START, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(5, 40))
          send_beat(($urandom_range(0, 7) == 0) ? OP_START : OP_TICK, 1'($urandom_range(0, 1)));
      end
      to_idle();
      readings++;
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.report("readouts never returned", 0, sb.pending());
    $display("Ran %0d readings over %0d timing sets: %0d good frames, %0d timeouts, %0d bad sums",
             sb.good_frames + sb.timeouts + sb.bad_sums, timing_sets, sb.good_frames,
             sb.timeouts, sb.bad_sums);
    $display("%0d readout beats checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("single_wire_humidity_sensor_reader verification clean");
    end else begin
      $display("single_wire_humidity_sensor_reader verification failed");
    end
    $finish;
  end

endmodule
